### design/signed_int_to_decimal_ascii_defines.svh
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_defines.svh
// Assertion macros used by the integer-to-text top level.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define SIDAC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define SIDAC_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define SIDAC_ASSERT(lbl, clk, rstn, prop, msg)
`define SIDAC_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

### design/sidac_pkg.sv
// ---------------------------------------------------------------------------
// sidac_pkg
// Widths, types and character codes for the integer-to-text block.
// ---------------------------------------------------------------------------
package sidac_pkg;

    // Width of the input integer (8..64)
    localparam int VALUE_BITS = 32;
    // Decimal digits needed for the magnitude: floor(bits * log10(2)) + 1
    localparam int DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_BITS   = DIGITS * 4;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int LEFT_W     = $clog2(DIGITS + 1);

    localparam logic [7:0] ASCII_MINUS = 8'd45;
    localparam logic [7:0] ASCII_ZERO  = 8'd48;

    typedef logic [VALUE_BITS-1:0] mag_t;
    typedef logic [BCD_BITS-1:0]   bcd_t;

    // Request into the binary-to-BCD converter
    typedef struct packed {
        logic start;
        mag_t mag;
    } dab_ctrl_t;

    // Result from the converter
    typedef struct packed {
        logic done;
        bcd_t bcd;
    } dab_stat_t;

    // Shift-and-add-3 correction of one BCD digit
    function automatic logic [3:0] dab_adjust(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? d + 4'd3 : d;
        return r;
    endfunction

endpackage

### design/sidac_dabble.sv
// ---------------------------------------------------------------------------
// sidac_dabble
// Bit-serial binary-to-BCD converter (double dabble), one magnitude bit
// per cycle. done pulses for one cycle when the BCD result is ready.
// ---------------------------------------------------------------------------
module sidac_dabble (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sidac_pkg::dab_ctrl_t  ctrl,
    output sidac_pkg::dab_stat_t  stat
);
    import sidac_pkg::*;

    mag_t             mag_reg,  mag_next;
    bcd_t             bcd_reg,  bcd_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             done_reg, done_next;
    bcd_t             bcd_adj;

    // Per-digit correction before each shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = dab_adjust(bcd_reg[i*4 +: 4]);
        end
    end

    // Shift sequencer
    always_comb
    begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            mag_next = ctrl.mag;
            bcd_next = '0;
            cnt_next = CNT_W'(VALUE_BITS);
        end
        else if (cnt_reg != '0)
        begin
            bcd_next  = {bcd_adj[BCD_BITS-2:0], mag_reg[VALUE_BITS-1]};
            mag_next  = {mag_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign stat.done = done_reg;
    assign stat.bcd  = bcd_reg;

endmodule

### design/signed_int_to_decimal_ascii.sv
// Conversion time is set by the one-bit-per-cycle double-dabble loop, and output
//   by one character per cycle while out_stall is low.
// Characters leave through an output register; one number is converted at a time.
// Reset (rst_n, async, active low) clears the sequencer and output valid.
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text, one character per
// output transfer, sign first, no leading zeros, last character flagged.
// ---------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sidac_pkg::VALUE_BITS-1:0] value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          char_code,
    output logic                                last_char
);
    import sidac_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_SKIP  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;

    logic [2:0]        state_reg,  state_next;
    logic              neg_reg,    neg_next;
    bcd_t              dig_reg,    dig_next;
    logic [LEFT_W-1:0] left_reg,   left_next;
    logic              ovld_reg,   ovld_next;
    logic [7:0]        char_reg,   char_next;
    logic              last_reg,   last_next;

    dab_ctrl_t dab_ctrl;
    dab_stat_t dab_stat;
    logic      in_xfer;
    logic      slot_free;
    logic [3:0] top_dig;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign slot_free = !ovld_reg || !out_stall;
    assign top_dig   = dig_reg[BCD_BITS-1 -: 4];

    // Start the converter on the unsigned magnitude
    assign dab_ctrl.start = in_xfer;
    assign dab_ctrl.mag   = value[VALUE_BITS-1] ? mag_t'(~value + 1'b1) : mag_t'(value);

    sidac_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dab_ctrl),
        .stat  (dab_stat)
    );

    // Sequencer: convert, drop leading zeros, emit sign and digits
    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        dig_next   = dig_reg;
        left_next  = left_reg;
        ovld_next  = ovld_reg && out_stall;
        char_next  = char_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    neg_next   = value[VALUE_BITS-1];
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (dab_stat.done)
                begin
                    dig_next   = dab_stat.bcd;
                    left_next  = LEFT_W'(DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Keep at least one digit so zero prints as "0"
                if (top_dig == 4'd0 && left_reg != LEFT_W'(1))
                begin
                    dig_next  = {dig_reg[BCD_BITS-5:0], 4'b0};
                    left_next = left_reg - 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    ovld_next  = 1'b1;
                    char_next  = ASCII_MINUS;
                    last_next  = 1'b0;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (slot_free)
                begin
                    ovld_next = 1'b1;
                    char_next = ASCII_ZERO + {4'b0, top_dig};
                    last_next = (left_reg == LEFT_W'(1));
                    dig_next  = {dig_reg[BCD_BITS-5:0], 4'b0};
                    left_next = left_reg - 1'b1;
                    if (left_reg == LEFT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        dig_reg  <= dig_next;
        left_reg <= left_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = ovld_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

    // Checks
    `SIDAC_ASSERT(a_done_in_conv, clk, rst_n,
        dab_stat.done |-> state_reg == ST_CONV, "converter done outside conversion")
    `SIDAC_ASSERT(a_xfer_to_conv, clk, rst_n,
        in_xfer |=> state_reg == ST_CONV, "input transfer did not start conversion")
    `SIDAC_ASSERT(a_char_legal, clk, rst_n,
        ovld_reg |-> (char_reg == ASCII_MINUS ||
            (char_reg >= ASCII_ZERO && char_reg <= ASCII_ZERO + 8'd9)),
        "illegal character code")
    `SIDAC_NEVER(a_minus_last, clk, rst_n,
        ovld_reg && last_reg && char_reg == ASCII_MINUS, "sign flagged as last character")

endmodule
